@@ src/sajs_pkg.sv @@
// ----------------------------------------------------------------------------
// sajs_pkg
// shared types, codes and constants of the stepper axis jog and seek block
// ----------------------------------------------------------------------------
package sajs_pkg;

	// width of the internal step counter; the position output is its low 16 bits
	localparam int POS_W = 16;
	// width used when the counter is compared with the 16-bit travel limit
	localparam int CMP_W = (POS_W > 16) ? POS_W : 16;

	localparam logic [15:0] TRAVEL_LIMIT_RESET = 16'd25800;

	// operation codes
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_JOG     = 2'd1;
	localparam logic [1:0] OP_SEEK    = 2'd2;
	localparam logic [1:0] OP_SET_POS = 2'd3;

	// jog codes
	localparam logic [1:0] JOG_STOP   = 2'd0;
	localparam logic [1:0] JOG_FIRST  = 2'd1;
	localparam logic [1:0] JOG_SECOND = 2'd2;

	// seek states
	localparam logic [1:0] SEEK_IDLE = 2'd0;
	localparam logic [1:0] SEEK_DOWN = 2'd1;
	localparam logic [1:0] SEEK_UP   = 2'd2;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_TRAVEL_LIMIT    = 2'd0;
	localparam logic [1:0] REG_JOG_SWAP        = 2'd1;
	localparam logic [1:0] REG_DIR_INVERT      = 2'd2;
	localparam logic [1:0] REG_RELEASE_ARRIVAL = 2'd3;

	localparam int APB_ADDR_W = 4;

	typedef struct packed {
		logic [15:0] travel_limit;
		logic        jog_sense_swapped;
		logic        direction_pin_inverted;
		logic        release_on_arrival;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [1:0]  jog_code;
		logic [15:0] position_value;
	} item_t;

	typedef struct packed {
		logic        step_level;
		logic        direction_level;
		logic        enable_level;
		logic [15:0] position;
		logic [1:0]  seek_mode;
	} result_t;

endpackage

@@ src/sajs_cfg.sv @@
// ----------------------------------------------------------------------------
// sajs_cfg
// apb register file holding travel limit, the two axis sense bits and the release-on-arrival bit
// ----------------------------------------------------------------------------
module sajs_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sajs_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output sajs_pkg::cfg_t                     cfg
);

	sajs_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.travel_limit           <= sajs_pkg::TRAVEL_LIMIT_RESET;
			cfg_q.jog_sense_swapped      <= 1'b0;
			cfg_q.direction_pin_inverted <= 1'b0;
			cfg_q.release_on_arrival     <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				sajs_pkg::REG_TRAVEL_LIMIT:    cfg_q.travel_limit           <= pwdata[15:0];
				sajs_pkg::REG_JOG_SWAP:        cfg_q.jog_sense_swapped      <= pwdata[0];
				sajs_pkg::REG_DIR_INVERT:      cfg_q.direction_pin_inverted <= pwdata[0];
				sajs_pkg::REG_RELEASE_ARRIVAL: cfg_q.release_on_arrival     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sajs_pkg::REG_TRAVEL_LIMIT:    prdata = {16'd0, cfg_q.travel_limit};
			sajs_pkg::REG_JOG_SWAP:        prdata = {31'd0, cfg_q.jog_sense_swapped};
			sajs_pkg::REG_DIR_INVERT:      prdata = {31'd0, cfg_q.direction_pin_inverted};
			sajs_pkg::REG_RELEASE_ARRIVAL: prdata = {31'd0, cfg_q.release_on_arrival};
			default:                       prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ src/sajs_core.sv @@
// ----------------------------------------------------------------------------
// sajs_core
// axis state registers and the combinational update for a single item
// ----------------------------------------------------------------------------
module sajs_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  sajs_pkg::item_t     item,
	input  sajs_pkg::cfg_t      cfg,
	output sajs_pkg::result_t   result
);

	localparam int PW = sajs_pkg::POS_W;
	localparam int CW = sajs_pkg::CMP_W;

	logic [PW-1:0] pos_q, pos_d;
	logic          pulse_q, pulse_d;
	logic [1:0]    jog_q, jog_d;
	logic [1:0]    seek_q, seek_d;
	logic [PW-1:0] target_q, target_d;
	logic          enable_q, enable_d;
	logic          up_q, up_d;

	logic          jog_up;
	logic          jog_can_up;
	logic          jog_can_down;
	logic          seek_active;
	logic          step_dir_up;
	logic          do_step;
	logic [PW-1:0] stepped_pos;
	logic [PW-1:0] val_pos;

	assign val_pos      = PW'(item.position_value);
	assign jog_up       = (jog_q == sajs_pkg::JOG_FIRST) ^ cfg.jog_sense_swapped;
	assign jog_can_up   = (jog_q != sajs_pkg::JOG_STOP) && jog_up &&
	                      (CW'(pos_q) < CW'(cfg.travel_limit));
	assign jog_can_down = (jog_q != sajs_pkg::JOG_STOP) && !jog_up && (pos_q != '0);
	assign seek_active  = (seek_q == sajs_pkg::SEEK_DOWN) || (seek_q == sajs_pkg::SEEK_UP);
	assign step_dir_up  = (jog_can_up || jog_can_down) ? jog_up : (seek_q == sajs_pkg::SEEK_UP);
	assign do_step      = jog_can_up || jog_can_down || seek_active;
	// position only moves on the rising half of the pulse
	assign stepped_pos  = pulse_q ? pos_q : (step_dir_up ? pos_q + PW'(1) : pos_q - PW'(1));

	always_comb begin
		pos_d    = pos_q;
		pulse_d  = pulse_q;
		jog_d    = jog_q;
		seek_d   = seek_q;
		target_d = target_q;
		enable_d = enable_q;
		up_d     = up_q;
		case (item.operation)
			sajs_pkg::OP_TICK: begin
				if (do_step) begin
					pulse_d = !pulse_q;
					pos_d   = stepped_pos;
					// arrival check only when the seek serves the tick
					if (!(jog_can_up || jog_can_down) && (stepped_pos == target_q)) begin
						seek_d = sajs_pkg::SEEK_IDLE;
						if (cfg.release_on_arrival)
							enable_d = 1'b0;
					end
				end
			end
			sajs_pkg::OP_JOG: begin
				if ((item.jog_code == sajs_pkg::JOG_FIRST) ||
				    (item.jog_code == sajs_pkg::JOG_SECOND)) begin
					jog_d    = item.jog_code;
					up_d     = (item.jog_code == sajs_pkg::JOG_FIRST) ^ cfg.jog_sense_swapped;
					enable_d = 1'b1;
				end else begin
					jog_d = sajs_pkg::JOG_STOP;
					if (seek_q == sajs_pkg::SEEK_IDLE)
						enable_d = 1'b0;
				end
			end
			sajs_pkg::OP_SEEK: begin
				target_d = val_pos;
				if (pos_q > val_pos) begin
					seek_d   = sajs_pkg::SEEK_DOWN;
					up_d     = 1'b0;
					enable_d = 1'b1;
				end else if (pos_q < val_pos) begin
					seek_d   = sajs_pkg::SEEK_UP;
					up_d     = 1'b1;
					enable_d = 1'b1;
				end
			end
			default: begin
				pos_d = val_pos;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			pulse_q  <= 1'b0;
			jog_q    <= sajs_pkg::JOG_STOP;
			seek_q   <= sajs_pkg::SEEK_IDLE;
			target_q <= '0;
			enable_q <= 1'b0;
			up_q     <= 1'b0;
		end else if (advance) begin
			pos_q    <= pos_d;
			pulse_q  <= pulse_d;
			jog_q    <= jog_d;
			seek_q   <= seek_d;
			target_q <= target_d;
			enable_q <= enable_d;
			up_q     <= up_d;
		end
	end

	assign result.step_level      = pulse_d;
	assign result.direction_level = up_d ^ cfg.direction_pin_inverted;
	assign result.enable_level    = enable_d;
	assign result.position        = 16'(pos_d);
	assign result.seek_mode       = seek_d;

endmodule

@@ src/stepper_axis_jog_and_seek.sv @@
// ----------------------------------------------------------------------------
// stepper_axis_jog_and_seek
// step pulse generator for one stepper axis with manual jog and target seek
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one item per transfer: s_axis_tuser is the operation
//   (tick, jog command, load seek target, set position), s_axis_tdata holds
//   the jog code and the position value. m_axis returns exactly one result
//   per item: step, direction and enable pin levels, position and seek mode.
//   the apb port sets travel limit, jog sense, direction pin sense and the
//   release-on-arrival bit; write it only while no item is in flight.
// pipeline: each item passes the input register, then the result register,
//   before its result shows on m_axis. throughput: one item per cycle while
//   m_axis_tready is high, set by the state update between the two registers.
// stall: when m_axis_tready is low the result register holds; one more item
//   waits in the input register, then s_axis_tready drops.
// reset: arst_n clears both pipeline stages and the axis state (position,
//   pulse, jog, seek, enable, direction) and loads the register defaults.
// ----------------------------------------------------------------------------
module stepper_axis_jog_and_seek (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [23:0]                        s_axis_tdata,  // jog_code[1:0], position_value[17:2], zero pad
	input  logic [1:0]                         s_axis_tuser,  // operation[1:0]
	// result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [23:0]                        m_axis_tdata,  // step_level[0], direction_level[1],
	                                                          // enable_level[2], position[18:3],
	                                                          // seek_mode[20:19], zero pad
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sajs_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	sajs_pkg::cfg_t    cfg;
	sajs_pkg::item_t   item_s1;
	sajs_pkg::result_t result_next;
	sajs_pkg::result_t result_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	// the item in stage 1 moves on when the result register is free or drains
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	sajs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.operation      <= s_axis_tuser;
			item_s1.jog_code       <= s_axis_tdata[1:0];
			item_s1.position_value <= s_axis_tdata[17:2];
		end
	end

	// state update for the item in stage 1
	sajs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result_next)
	);

	// result register, holds while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'd0, result_s2.seek_mode, result_s2.position,
	                        result_s2.enable_level, result_s2.direction_level,
	                        result_s2.step_level};

endmodule

@@ src/sajs_checker.sv @@
// ----------------------------------------------------------------------------
// sajs_checker
// port-level checks of the stepper axis block, bound to the top level
// ----------------------------------------------------------------------------
module sajs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// no result shows while reset is applied
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// a stalled result keeps its value
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// a running seek always has the driver enabled
	a_seek_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[20:19] != sajs_pkg::SEEK_IDLE) |-> m_axis_tdata[2])
		else $error("seek running with driver disabled");

	// a draining output never blocks the input side
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

endmodule

bind stepper_axis_jog_and_seek sajs_checker u_sajs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
